// File: hdl/cfla_pkg.sv
// ----------------------------------------------------------------------------
// Chunked free list allocator package
// Shared types and constants for the pool allocator: payload words, status
// and command codes, and the sequencer states.
// ----------------------------------------------------------------------------
package cfla_pkg;

  localparam int SLOT_FIELD_W = 10;
  localparam int CHUNK_W      = 11;
  localparam int COUNT_W      = 32;
  localparam int REFILL_W     = 11;
  localparam int STATUS_W     = 2;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd50;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;

  typedef struct packed {
    logic                    command;
    logic [SLOT_FIELD_W-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      alloc_total;
    logic [REFILL_W-1:0]     refill_total;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CARVE,
    S_READ,
    S_POP,
    S_DONE
  } state_t;

endpackage

// File: hdl/chunked_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Chunked free list allocator
// Fixed-slot pool with a linked free list held in a link memory. Allocate
// pops the list head, carving a new chunk of slots when the list is empty and
// the pool is not yet fully carved; free pushes a slot from the carved region onto the head.
// ----------------------------------------------------------------------------
// Sequencing: a free or an exhausted allocate goes from DECIDE straight to DONE; an
// allocate from a non-empty list passes READ and POP, and a refill first writes one
// link entry per carved slot in CARVE. One word is in work at a time; the next is
// accepted in the cycle after the result enters the output register. Reset is
// synchronous: control registers clear, chunk_slots returns to 50, and the link
// memory is not cleared.
module chunked_free_list_allocator #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [cfla_pkg::CHUNK_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cfla_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cfla_pkg::out_word_t                out_data
);

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int WIDE_W = (CNT_W > cfla_pkg::CHUNK_W) ? CNT_W : cfla_pkg::CHUNK_W;
  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SLOTS);
  localparam logic [WIDE_W-1:0] POOL_WIDE = WIDE_W'(POOL_SLOTS);

  cfla_pkg::state_t state, state_next;

  logic [cfla_pkg::CHUNK_W-1:0]  chunk_slots;
  logic [SLOT_W-1:0]             free_head;
  logic                          list_empty;
  logic [CNT_W-1:0]              carved_top;
  logic [cfla_pkg::COUNT_W-1:0]  alloc_count;
  logic [cfla_pkg::REFILL_W-1:0] chunk_count;

  logic                          cmd;
  logic [cfla_pkg::SLOT_FIELD_W-1:0] slot_in;
  logic [CNT_W-1:0]              carve_addr;
  logic [CNT_W-1:0]              carve_end;
  logic [cfla_pkg::SLOT_FIELD_W-1:0] res_granted;
  logic [cfla_pkg::STATUS_W-1:0] res_status;

  logic [SLOT_W:0]               link_mem [POOL_SLOTS];
  logic [SLOT_W:0]               rd_data;
  logic                          mem_we;
  logic [SLOT_W-1:0]             mem_waddr;
  logic [SLOT_W:0]               mem_wdata;

  logic [WIDE_W-1:0]             slot_wide;
  logic                          bad_free;
  logic                          pool_full;
  logic [WIDE_W-1:0]             chunk_wide;
  logic [WIDE_W-1:0]             left_wide;
  logic [WIDE_W-1:0]             end_wide;
  logic [CNT_W-1:0]              carve_succ;
  logic                          carve_last;
  logic [SLOT_W-1:0]             carve_link;
  logic                          out_free;

  assign slot_wide  = WIDE_W'(slot_in);
  assign bad_free   = (slot_wide >= WIDE_W'(carved_top)) || (slot_wide >= POOL_WIDE);
  assign pool_full  = (carved_top >= POOL_CNT);
  assign chunk_wide = (chunk_slots == '0) ? WIDE_W'(1) : WIDE_W'(chunk_slots);
  assign left_wide  = POOL_WIDE - WIDE_W'(carved_top);
  assign end_wide   = (chunk_wide > left_wide) ? POOL_WIDE : WIDE_W'(carved_top) + chunk_wide;
  assign carve_succ = carve_addr + CNT_W'(1);
  assign carve_last = (carve_succ == carve_end);
  assign carve_link = (carve_succ == POOL_CNT) ? '0 : carve_succ[SLOT_W-1:0];
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      cfla_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = cfla_pkg::S_DECIDE;
        end
      end
      cfla_pkg::S_DECIDE: begin
        if (cmd == cfla_pkg::CMD_FREE) begin
          state_next = cfla_pkg::S_DONE;
        end else if (!list_empty) begin
          state_next = cfla_pkg::S_READ;
        end else if (pool_full) begin
          state_next = cfla_pkg::S_DONE;
        end else begin
          state_next = cfla_pkg::S_CARVE;
        end
      end
      cfla_pkg::S_CARVE: begin
        if (carve_last) begin
          state_next = cfla_pkg::S_READ;
        end
      end
      cfla_pkg::S_READ: state_next = cfla_pkg::S_POP;
      cfla_pkg::S_POP:  state_next = cfla_pkg::S_DONE;
      cfla_pkg::S_DONE: begin
        if (out_free) begin
          state_next = cfla_pkg::S_IDLE;
        end
      end
      default: state_next = cfla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = carve_addr[SLOT_W-1:0];
    mem_wdata = {carve_last, carve_link};
    unique case (state)
      cfla_pkg::S_IDLE: in_ready = 1'b1;
      cfla_pkg::S_DECIDE: begin
        if (cmd == cfla_pkg::CMD_FREE && !bad_free) begin
          mem_we    = 1'b1;
          mem_waddr = slot_wide[SLOT_W-1:0];
          mem_wdata = {list_empty, free_head};
        end
      end
      cfla_pkg::S_CARVE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= link_mem[free_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cfla_pkg::S_IDLE;
      chunk_slots <= cfla_pkg::CHUNK_RESET;
      free_head   <= '0;
      list_empty  <= 1'b1;
      carved_top  <= '0;
      alloc_count <= '0;
      chunk_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        chunk_slots <= cfg_wdata;
      end
      if (state == cfla_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        cfla_pkg::S_IDLE: begin
          cmd     <= in_data.command;
          slot_in <= in_data.slot_index;
        end
        cfla_pkg::S_DECIDE: begin
          res_granted <= '0;
          carve_addr  <= carved_top;
          carve_end   <= end_wide[CNT_W-1:0];
          if (cmd == cfla_pkg::CMD_FREE && bad_free) begin
            res_status <= cfla_pkg::ST_BAD_FREE;
          end else if (cmd == cfla_pkg::CMD_ALLOC && list_empty && pool_full) begin
            res_status <= cfla_pkg::ST_EXHAUSTED;
          end else begin
            res_status <= cfla_pkg::ST_OK;
          end
          if (cmd == cfla_pkg::CMD_FREE && !bad_free) begin
            free_head  <= slot_wide[SLOT_W-1:0];
            list_empty <= 1'b0;
          end
        end
        cfla_pkg::S_CARVE: begin
          carve_addr <= carve_succ;
          if (carve_last) begin
            free_head  <= carved_top[SLOT_W-1:0];
            list_empty <= 1'b0;
            carved_top <= carve_end;
            if (chunk_count != '1) begin
              chunk_count <= chunk_count + cfla_pkg::REFILL_W'(1);
            end
          end
        end
        cfla_pkg::S_READ: ;
        cfla_pkg::S_POP: begin
          res_granted <= cfla_pkg::SLOT_FIELD_W'(free_head);
          list_empty  <= rd_data[SLOT_W];
          free_head   <= rd_data[SLOT_W-1:0];
          if (alloc_count != '1) begin
            alloc_count <= alloc_count + cfla_pkg::COUNT_W'(1);
          end
        end
        cfla_pkg::S_DONE: begin
          if (out_free) begin
            out_data.granted_slot <= res_granted;
            out_data.status       <= res_status;
            out_data.alloc_total  <= alloc_count;
            out_data.refill_total <= chunk_count;
          end
        end
        default: ;
      endcase
    end
  end

  a_carved_in_pool: assert property (@(posedge clk) disable iff (rst)
    carved_top <= POOL_CNT)
    else $error("Carved region runs past the end of the pool.");

  a_pop_needs_list: assert property (@(posedge clk) disable iff (rst)
    (state == cfla_pkg::S_READ) |-> !list_empty)
    else $error("Pop started on an empty free list.");

  a_carve_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == cfla_pkg::S_CARVE) |-> (carve_addr < carve_end) && (carve_end <= POOL_CNT))
    else $error("Refill write address outside the chunk being carved.");

  a_alloc_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> alloc_count >= $past(alloc_count))
    else $error("Allocation count went backwards.");

endmodule
